// ===== rtl/prt_pkg.sv =====
// Shared types and constants for the palette RGB555 threshold block.
`timescale 1ns / 1ps

package prt_pkg;

   // Channel and field widths
   localparam int CHAN_W        = 8;
   localparam int INDEX_W       = 4;
   localparam int COLOR_W       = 15;
   localparam int ROW_WIDTH_W   = 13;
   localparam int THRESHOLD_W   = 8;
   localparam int CSR_DATA_W    = 13;
   localparam int CSR_INDEX_W   = 1;
   localparam int PALETTE_DEPTH = 16;

   // Default row width limit handed to the top level
   localparam int MAX_ROW_WIDTH_DEF = 4096;

   // Command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LUMA_THRESHOLD = 1'b1;

   // Register reset values
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST      = 13'd1;
   localparam logic [THRESHOLD_W-1:0] LUMA_THRESHOLD_RST = 8'd128;

   // Luma weights; the weighted sum fits 18 bits (255 * 1000 and 256 * 1000)
   localparam int LUMA_W      = 18;
   localparam int LUMA_R_COEF = 299;
   localparam int LUMA_G_COEF = 587;
   localparam int LUMA_B_COEF = 114;
   localparam int LUMA_DIV    = 1000;

   localparam logic [COLOR_W-1:0] WHITE555 = 15'h7FFF;
   localparam logic [COLOR_W-1:0] BLACK555 = 15'h0000;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic              command;
      logic [INDEX_W-1:0] entry_index;
      logic [CHAN_W-1:0] entry_red;
      logic [CHAN_W-1:0] entry_green;
      logic [CHAN_W-1:0] entry_blue;
      logic [CHAN_W-1:0] packed_pixels;
   } req_word_type;

   typedef struct packed {
      logic [COLOR_W-1:0] color_first;
      logic [COLOR_W-1:0] mono_first;
      logic [COLOR_W-1:0] color_second;
      logic [COLOR_W-1:0] mono_second;
      logic               second_valid;
      logic               row_end;
   } rsp_word_type;

   // Row position flags from the column tracker
   typedef struct packed {
      logic second_valid;
      logic row_end;
   } col_flags_type;

endpackage

// ===== rtl/prt_palette_mem.sv =====
// Palette memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module prt_palette_mem (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [prt_pkg::INDEX_W-1:0]          wr_addr,
   input  prt_pkg::rgb_type                     wr_data,
   input  logic                                 rd_en,
   input  logic [prt_pkg::INDEX_W-1:0]          rd_addr_a,
   input  logic [prt_pkg::INDEX_W-1:0]          rd_addr_b,
   output prt_pkg::rgb_type                     rd_data_a,
   output prt_pkg::rgb_type                     rd_data_b
);
   import prt_pkg::*;

   rgb_type mem [PALETTE_DEPTH];
   rgb_type rd_a_ff;
   rgb_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/prt_pixel_conv.sv =====
// Pixel converter: RGB555 packing and luma threshold for one palette entry.
`timescale 1ns / 1ps

module prt_pixel_conv (
   input  prt_pkg::rgb_type                  entry,
   input  logic [prt_pkg::THRESHOLD_W-1:0]   threshold,
   output logic [prt_pkg::COLOR_W-1:0]       color,
   output logic [prt_pkg::COLOR_W-1:0]       mono
);
   import prt_pkg::*;

   logic [LUMA_W-1:0]      luma_sum;
   logic [THRESHOLD_W:0]   thr_plus;
   logic [LUMA_W-1:0]      luma_bound;

   // floor(sum / 1000) > thr  <=>  sum >= 1000 * (thr + 1)
   assign luma_sum = LUMA_W'(entry.red)   * LUMA_W'(LUMA_R_COEF)
                   + LUMA_W'(entry.green) * LUMA_W'(LUMA_G_COEF)
                   + LUMA_W'(entry.blue)  * LUMA_W'(LUMA_B_COEF);

   assign thr_plus   = {1'b0, threshold} + (THRESHOLD_W + 1)'(1);
   assign luma_bound = LUMA_W'(thr_plus) * LUMA_W'(LUMA_DIV);

   assign color = {entry.red[CHAN_W-1 -: 5], entry.green[CHAN_W-1 -: 5],
                   entry.blue[CHAN_W-1 -: 5]};
   assign mono  = (luma_sum >= luma_bound) ? WHITE555 : BLACK555;

endmodule

// ===== rtl/prt_column.sv =====
// Column tracker: counts pixels within a row and flags second pixel and row end.
`timescale 1ns / 1ps

module prt_column #(
   parameter int MAX_ROW_WIDTH = prt_pkg::MAX_ROW_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [prt_pkg::ROW_WIDTH_W-1:0]    row_width,
   output prt_pkg::col_flags_type             flags
);
   import prt_pkg::*;

   localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
   localparam int WW     = $clog2(MAX_ROW_WIDTH + 1);
   localparam int CALC_W = ((WW > ROW_WIDTH_W) ? WW : ROW_WIDTH_W) + 1;

   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [CALC_W-1:0] width_eff;
   logic [CALC_W-1:0] col_ext;
   logic [CALC_W-1:0] col_next;
   logic              second;
   logic              last;

   // Clamp the width to 1..MAX_ROW_WIDTH
   always_comb begin
      if (row_width == '0) begin
         width_eff = CALC_W'(1);
      end else if (CALC_W'(row_width) > CALC_W'(MAX_ROW_WIDTH)) begin
         width_eff = CALC_W'(MAX_ROW_WIDTH);
      end else begin
         width_eff = CALC_W'(row_width);
      end
   end

   assign col_ext  = CALC_W'(col_ff);
   assign second   = (col_ext + CALC_W'(1)) < width_eff;
   assign col_next = col_ext + (second ? CALC_W'(2) : CALC_W'(1));
   assign last     = col_next >= width_eff;

   always_comb begin
      col_in = col_ff;
      if (advance) begin
         col_in = last ? '0 : col_next[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   assign flags.second_valid = second;
   assign flags.row_end      = last;

endmodule

// ===== rtl/palette_rgb555_threshold_top.sv =====
// Top level: palette 4-bit to RGB555 converter with luma threshold output.
// Path: a pixel word is read from the palette into the lookup stage, then converted
// into the result register. One word per cycle while req_stall is low; load words
// take the same slot and give no result.
// Reset: synchronous; clears pipeline valids, column count and registers to defaults.
`timescale 1ns / 1ps

module palette_rgb555_threshold_top #(
   parameter int MAX_ROW_WIDTH = prt_pkg::MAX_ROW_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  prt_pkg::req_word_type              req_word,
   // Result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output prt_pkg::rsp_word_type              rsp_word,
   // Register write port
   input  logic                               csr_write_en,
   input  logic [prt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [prt_pkg::CSR_DATA_W-1:0]     csr_data
);
   import prt_pkg::*;

   // Configuration registers
   logic [ROW_WIDTH_W-1:0]  row_width_ff;
   logic [THRESHOLD_W-1:0]  luma_threshold_ff;

   // Lookup stage (palette read data lives in the memory)
   logic           s1_vld_ff;
   logic           s1_vld_in;
   col_flags_type  s1_flags_ff;

   // Result stage
   logic           rsp_valid_ff;
   rsp_word_type   rsp_word_ff;
   rsp_word_type   rsp_word_in;

   logic           req_accept;
   logic           pix_accept;
   logic           load_accept;
   logic           out_adv;

   col_flags_type  col_flags;
   rgb_type        entry_first;
   rgb_type        entry_second;
   rgb_type        load_entry;
   logic [COLOR_W-1:0] color_a;
   logic [COLOR_W-1:0] mono_a;
   logic [COLOR_W-1:0] color_b;
   logic [COLOR_W-1:0] mono_b;

   // ------------------------------------------------------------------
   // Handshake: the result register drains when empty or taken; the lookup
   // stage moves forward whenever the result register can take it.
   // ------------------------------------------------------------------
   assign out_adv     = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_vld_ff && !out_adv;
   assign req_accept  = req_valid && !req_stall;
   assign pix_accept  = req_accept && (req_word.command == CMD_PIXEL);
   assign load_accept = req_accept && (req_word.command == CMD_LOAD);

   // ------------------------------------------------------------------
   // Register writes; unknown indexes fall to the default arm and drop.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff      <= ROW_WIDTH_RST;
         luma_threshold_ff <= LUMA_THRESHOLD_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ROW_WIDTH:      row_width_ff      <= csr_data[ROW_WIDTH_W-1:0];
            CSR_LUMA_THRESHOLD: luma_threshold_ff <= csr_data[THRESHOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Palette: loads write at accept; a pixel reads both nibbles at accept,
   // so a load just before is already visible.
   // ------------------------------------------------------------------
   assign load_entry.red   = req_word.entry_red;
   assign load_entry.green = req_word.entry_green;
   assign load_entry.blue  = req_word.entry_blue;

   prt_palette_mem u_palette (
      .clock     (clock),
      .wr_en     (load_accept),
      .wr_addr   (req_word.entry_index),
      .wr_data   (load_entry),
      .rd_en     (pix_accept),
      .rd_addr_a (req_word.packed_pixels[CHAN_W-1 -: INDEX_W]),
      .rd_addr_b (req_word.packed_pixels[INDEX_W-1:0]),
      .rd_data_a (entry_first),
      .rd_data_b (entry_second)
   );

   // Column position advances on each pixel word; loads leave it alone.
   prt_column #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
   ) u_column (
      .clock     (clock),
      .reset     (reset),
      .advance   (pix_accept),
      .row_width (row_width_ff),
      .flags     (col_flags)
   );

   // Hold the lookup stage while stalled, otherwise take the next pixel.
   assign s1_vld_in = req_stall ? s1_vld_ff : pix_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         s1_flags_ff <= col_flags;
      end
   end

   // ------------------------------------------------------------------
   // Convert both pixels; blank the second one when it falls past the row.
   // ------------------------------------------------------------------
   prt_pixel_conv u_conv_first (
      .entry     (entry_first),
      .threshold (luma_threshold_ff),
      .color     (color_a),
      .mono      (mono_a)
   );

   prt_pixel_conv u_conv_second (
      .entry     (entry_second),
      .threshold (luma_threshold_ff),
      .color     (color_b),
      .mono      (mono_b)
   );

   always_comb begin
      rsp_word_in.color_first  = color_a;
      rsp_word_in.mono_first   = mono_a;
      rsp_word_in.color_second = s1_flags_ff.second_valid ? color_b : BLACK555;
      rsp_word_in.mono_second  = s1_flags_ff.second_valid ? mono_b : BLACK555;
      rsp_word_in.second_valid = s1_flags_ff.second_valid;
      rsp_word_in.row_end      = s1_flags_ff.row_end;
   end

   // Result register: load when the slot frees up, hold while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && s1_vld_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   // A result only appears after a word sat in the lookup stage.
   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_vld_ff))
      else $error("result appeared without a looked-up word");

   // Input back-pressure only comes from an occupied lookup stage.
   a_stall_needs_s1: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff)
      else $error("input stalled with empty lookup stage");

   // A looked-up word held by back-pressure is not lost.
   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !out_adv) |=> s1_vld_ff)
      else $error("lookup stage dropped a stalled word");

   // A second pixel outside the row is blank in the result.
   a_second_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.second_valid) |->
         (rsp_word_ff.color_second == BLACK555 && rsp_word_ff.mono_second == BLACK555))
      else $error("second pixel not blanked outside the row");
`endif

endmodule
